@@ hw/rtl/ghd_pkg.sv @@
// shared types, widths, constants and the arctangent table for the goal heading block
package ghd_pkg;

   // field widths
   localparam int COORD_WIDTH = 24;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int MAG_W       = COORD_WIDTH;
   localparam int HEAD_W      = 16;
   localparam int DIST_W      = COORD_WIDTH + 1;
   localparam int TURN_W      = 16;

   // internal widths
   localparam int RAD_W       = 2 * MAG_W + 1;
   localparam int SQRT_STEPS  = (RAD_W + 1) / 2;
   localparam int NORM_BIT    = 52;
   localparam int CX_W        = NORM_BIT + 5;
   localparam int Z_W         = 25;
   localparam int G_W         = 14;
   localparam int T_W         = TURN_W + 2;
   localparam int HEAD_K_W    = 24;
   localparam int HP_W        = HEAD_W + HEAD_K_W;
   localparam int ATAN_DEPTH  = 32;

   localparam int DEF_CORDIC_STAGES = 16;

   // angle constants, 1/128 degree unless noted
   localparam int HALF_TURN   = 23040;
   localparam int FULL_TURN   = 46080;
   localparam int QUARTER_Z   = 5898240;          // 90 degrees at 2^16 per degree
   localparam int Z_ROUND     = 256;
   localparam int Z_DROP      = 9;
   localparam logic [HEAD_K_W-1:0] HEAD_K = 24'd15019745;  // radians Q13 to 1/128 degree

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cur_x;
      logic signed [COORD_WIDTH-1:0] cur_y;
      logic signed [HEAD_W-1:0]      heading;
      logic signed [COORD_WIDTH-1:0] goal_x;
      logic signed [COORD_WIDTH-1:0] goal_y;
   } ghd_req_type;

   typedef struct packed {
      logic [DIST_W-1:0]        distance;
      logic signed [TURN_W-1:0] steer_angle;
      logic                     turn_right;
      logic                     at_goal;
   } ghd_rsp_type;

   // one item as it travels through the rotation and square root stages
   typedef struct packed {
      logic signed [CX_W-1:0]   x;
      logic signed [CX_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic [RAD_W-1:0]         rad;
      logic [RAD_W-1:0]         root;
      logic signed [HEAD_W-1:0] hd;
      logic                     neg_x;
      logic                     neg_y;
      logic                     at_goal;
   } ghd_iter_type;

   // atan(2^-i) in degrees times 2^16, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0: v = Z_W'(2949120);
         1: v = Z_W'(1740967);
         2: v = Z_W'(919879);
         3: v = Z_W'(466945);
         4: v = Z_W'(234379);
         5: v = Z_W'(117304);
         6: v = Z_W'(58666);
         7: v = Z_W'(29335);
         8: v = Z_W'(14668);
         9: v = Z_W'(7334);
         10: v = Z_W'(3667);
         11: v = Z_W'(1833);
         12: v = Z_W'(917);
         13: v = Z_W'(458);
         14: v = Z_W'(229);
         15: v = Z_W'(115);
         16: v = Z_W'(57);
         17: v = Z_W'(29);
         18: v = Z_W'(14);
         19: v = Z_W'(7);
         20: v = Z_W'(4);
         21: v = Z_W'(2);
         22: v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/ghd_iter.sv @@
// one registered core stage: a cordic vectoring rotation, one square root digit, or both, by stage index
module ghd_iter
   import ghd_pkg::*;
#(
   parameter int STAGE         = 0,
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         in_valid,
   input  ghd_iter_type in_data,
   output logic         out_valid,
   output ghd_iter_type out_data
);

   localparam bit DO_ROT  = (STAGE < CORDIC_STAGES) && (STAGE < ATAN_DEPTH);
   localparam bit DO_SQRT = STAGE < SQRT_STEPS;
   localparam int SQ_POS  = DO_SQRT ? 2 * (SQRT_STEPS - 1 - STAGE) : 0;
   localparam logic [RAD_W-1:0] SQRT_BIT = DO_SQRT ? (RAD_W'(1) << SQ_POS) : '0;
   localparam logic signed [Z_W-1:0] ATAN_Z = atan_deg(STAGE);

   logic                   valid_ff;
   ghd_iter_type           data_ff;
   ghd_iter_type           data_in;
   logic signed [CX_W-1:0] xs;
   logic signed [CX_W-1:0] ys;
   logic [RAD_W-1:0]       trial;

   // rotation toward the x axis and one root bit
   always_comb begin
      data_in = in_data;
      xs      = $signed(in_data.x) >>> STAGE;
      ys      = $signed(in_data.y) >>> STAGE;
      trial   = in_data.root + SQRT_BIT;
      if (DO_ROT) begin
         if (!in_data.y[CX_W-1]) begin
            data_in.x = in_data.x + ys;
            data_in.y = in_data.y - xs;
            data_in.z = in_data.z + ATAN_Z;
         end else begin
            data_in.x = in_data.x - ys;
            data_in.y = in_data.y + xs;
            data_in.z = in_data.z - ATAN_Z;
         end
      end
      if (DO_SQRT) begin
         if (in_data.rad >= trial) begin
            data_in.rad  = in_data.rad - trial;
            data_in.root = (in_data.root >> 1) + SQRT_BIT;
         end else begin
            data_in.root = in_data.root >> 1;
         end
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/goal_heading_and_distance_top.sv @@
// top level: distance and shortest turn toward a goal point
// One result per transfer, one transfer per cycle while req_stall is low. A
// request passes four front stages (difference, magnitude, squares and
// normalization, sum and heading scaling), one core stage per cordic
// rotation or square root digit, whichever count is larger (16 cordic stages
// by default), and three stages for angle rounding, quadrant fold and turn
// wrap. Results pass through a two-entry output queue; req_stall rises only
// when both entries hold results that rsp_stall keeps back, and while it is
// high the whole pipeline holds.
module goal_heading_and_distance_top
   import ghd_pkg::*;
#(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ghd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ghd_rsp_type rsp_data
);

   localparam int CORE_STAGES = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
   localparam int NORM_STEPS  = $clog2(MAG_W);
   localparam int NORM_SHIFT  = NORM_BIT - MAG_W + 1;
   localparam int BUF_DEPTH   = 2;
   localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
   localparam logic [MAG_W-1:0] MAG_ONES = {MAG_W{1'b1}};

   logic advance;

   // stage 1: coordinate differences
   logic                     s1_v_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff;
   logic signed [DIFF_W-1:0] s1_dy_ff;
   logic signed [HEAD_W-1:0] s1_h_ff;

   // stage 2: magnitudes and signs
   logic                     s2_v_ff;
   logic [MAG_W-1:0]         s2_ax_ff;
   logic [MAG_W-1:0]         s2_ay_ff;
   logic                     s2_neg_x_ff;
   logic                     s2_neg_y_ff;
   logic                     s2_goal_ff;
   logic [HEAD_W-1:0]        s2_hm_ff;
   logic                     s2_hneg_ff;

   // stage 3: squares, normalized vector, heading product
   logic                     s3_v_ff;
   logic [2*MAG_W-1:0]       s3_sqx_ff;
   logic [2*MAG_W-1:0]       s3_sqy_ff;
   logic [MAG_W-1:0]         s3_xn_ff;
   logic [MAG_W-1:0]         s3_yn_ff;
   logic [HP_W-1:0]          s3_hp_ff;
   logic                     s3_hneg_ff;
   logic                     s3_neg_x_ff;
   logic                     s3_neg_y_ff;
   logic                     s3_goal_ff;
   logic [MAG_W-1:0]         norm_x;
   logic [MAG_W-1:0]         norm_y;
   int                       norm_sh;

   // stage 4: core entry
   logic                     s4_v_ff;
   ghd_iter_type             s4_d_ff;
   ghd_iter_type             s4_d_in;
   logic [HP_W-1:0]          h_round;
   logic signed [HEAD_W-1:0] h_deg;

   // core chain
   logic                     core_v [0:CORE_STAGES];
   ghd_iter_type             core_d [0:CORE_STAGES];

   // end stages
   logic                     e1_v_ff;
   logic [G_W-1:0]           e1_g_ff;
   logic [DIST_W-1:0]        e1_dist_ff;
   logic signed [HEAD_W-1:0] e1_hd_ff;
   logic                     e1_neg_x_ff;
   logic                     e1_neg_y_ff;
   logic                     e1_goal_ff;
   logic signed [Z_W-1:0]    z_clamp;
   logic signed [Z_W-1:0]    z_round;

   logic                     e2_v_ff;
   logic signed [TURN_W-1:0] e2_g_ff;
   logic [DIST_W-1:0]        e2_dist_ff;
   logic signed [HEAD_W-1:0] e2_hd_ff;
   logic                     e2_goal_ff;
   logic signed [TURN_W-1:0] g_fold;
   logic signed [TURN_W-1:0] g_in;

   logic                     e3_v_ff;
   ghd_rsp_type              e3_d_ff;
   ghd_rsp_type              e3_d_in;
   logic signed [T_W-1:0]    turn_raw;
   logic signed [T_W-1:0]    turn_wrap;

   // output queue
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   ghd_rsp_type              head_ff;
   ghd_rsp_type              head_in;
   ghd_rsp_type              spare_ff;
   ghd_rsp_type              spare_in;
   logic                     push;
   logic                     pop;

   // the pipeline moves unless both queue entries are taken
   assign advance   = count_ff != CNT_W'(BUF_DEPTH);
   assign req_stall = !advance;

   // valid bits of the front and end stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
         e3_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         e1_v_ff <= core_v[CORE_STAGES];
         e2_v_ff <= e1_v_ff;
         e3_v_ff <= e2_v_ff;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx_ff <= DIFF_W'(req_data.goal_x) - DIFF_W'(req_data.cur_x);
         s1_dy_ff <= DIFF_W'(req_data.goal_y) - DIFF_W'(req_data.cur_y);
         s1_h_ff  <= req_data.heading;
      end
   end

   // stage 2 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_neg_x_ff <= s1_dx_ff[DIFF_W-1];
         s2_neg_y_ff <= s1_dy_ff[DIFF_W-1];
         s2_ax_ff    <= s1_dx_ff[DIFF_W-1] ? MAG_W'(-s1_dx_ff) : MAG_W'(s1_dx_ff);
         s2_ay_ff    <= s1_dy_ff[DIFF_W-1] ? MAG_W'(-s1_dy_ff) : MAG_W'(s1_dy_ff);
         s2_goal_ff  <= (s1_dx_ff == '0) && (s1_dy_ff == '0);
         s2_hneg_ff  <= s1_h_ff[HEAD_W-1];
         s2_hm_ff    <= s1_h_ff[HEAD_W-1] ? HEAD_W'(-s1_h_ff) : HEAD_W'(s1_h_ff);
      end
   end

   // normalize so the larger magnitude has its top bit set
   always_comb begin
      norm_x  = s2_ax_ff;
      norm_y  = s2_ay_ff;
      norm_sh = 0;
      for (int j = 0; j < NORM_STEPS; j++) begin
         norm_sh = 1 << (NORM_STEPS - 1 - j);
         if (((norm_x | norm_y) & ~(MAG_ONES >> norm_sh)) == '0) begin
            norm_x = norm_x << norm_sh;
            norm_y = norm_y << norm_sh;
         end
      end
   end

   // stage 3 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_sqx_ff   <= s2_ax_ff * s2_ax_ff;
         s3_sqy_ff   <= s2_ay_ff * s2_ay_ff;
         s3_xn_ff    <= norm_x;
         s3_yn_ff    <= norm_y;
         s3_hp_ff    <= HP_W'(s2_hm_ff) * HP_W'(HEAD_K);
         s3_hneg_ff  <= s2_hneg_ff;
         s3_neg_x_ff <= s2_neg_x_ff;
         s3_neg_y_ff <= s2_neg_y_ff;
         s3_goal_ff  <= s2_goal_ff;
      end
   end

   // heading to 1/128 degree, rounded half away from zero; core entry values
   always_comb begin
      h_round         = s3_hp_ff + (HP_W'(1) << (HEAD_K_W - 1));
      h_deg           = h_round[HP_W-1:HEAD_K_W];
      s4_d_in.x       = CX_W'(s3_xn_ff) << NORM_SHIFT;
      s4_d_in.y       = CX_W'(s3_yn_ff) << NORM_SHIFT;
      s4_d_in.z       = '0;
      s4_d_in.rad     = RAD_W'(s3_sqx_ff) + RAD_W'(s3_sqy_ff);
      s4_d_in.root    = '0;
      s4_d_in.hd      = s3_hneg_ff ? -h_deg : h_deg;
      s4_d_in.neg_x   = s3_neg_x_ff;
      s4_d_in.neg_y   = s3_neg_y_ff;
      s4_d_in.at_goal = s3_goal_ff;
   end

   // stage 4 payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s4_d_ff <= s4_d_in;
      end
   end

   assign core_v[0] = s4_v_ff;
   assign core_d[0] = s4_d_ff;

   // unrolled rotation and square root stages
   for (genvar k = 0; k < CORE_STAGES; k++) begin : g_core
      ghd_iter #(
         .STAGE         (k),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_iter (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (core_v[k]),
         .in_data   (core_d[k]),
         .out_valid (core_v[k+1]),
         .out_data  (core_d[k+1])
      );
   end

   // clamp the angle to the first quadrant and round to 1/128 degree
   always_comb begin
      if (core_d[CORE_STAGES].z < 0) begin
         z_clamp = '0;
      end else if (core_d[CORE_STAGES].z > Z_W'(QUARTER_Z)) begin
         z_clamp = Z_W'(QUARTER_Z);
      end else begin
         z_clamp = core_d[CORE_STAGES].z;
      end
      z_round = z_clamp + Z_W'(Z_ROUND);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_g_ff     <= z_round[G_W+Z_DROP-1:Z_DROP];
         e1_dist_ff  <= core_d[CORE_STAGES].root[DIST_W-1:0];
         e1_hd_ff    <= core_d[CORE_STAGES].hd;
         e1_neg_x_ff <= core_d[CORE_STAGES].neg_x;
         e1_neg_y_ff <= core_d[CORE_STAGES].neg_y;
         e1_goal_ff  <= core_d[CORE_STAGES].at_goal;
      end
   end

   // fold the angle into its quadrant by the difference signs
   always_comb begin
      g_fold = e1_neg_x_ff ? TURN_W'(HALF_TURN) - TURN_W'(e1_g_ff) : TURN_W'(e1_g_ff);
      g_in   = e1_neg_y_ff ? -g_fold : g_fold;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e2_g_ff    <= g_in;
         e2_dist_ff <= e1_dist_ff;
         e2_hd_ff   <= e1_hd_ff;
         e2_goal_ff <= e1_goal_ff;
      end
   end

   // bearing minus heading, one wrap into the half turn range
   always_comb begin
      turn_raw = T_W'(e2_g_ff) - T_W'(e2_hd_ff);
      if (turn_raw > T_W'(HALF_TURN)) begin
         turn_wrap = turn_raw - T_W'(FULL_TURN);
      end else if (turn_raw < -T_W'(HALF_TURN)) begin
         turn_wrap = turn_raw + T_W'(FULL_TURN);
      end else begin
         turn_wrap = turn_raw;
      end
      if (e2_goal_ff) begin
         e3_d_in.distance    = '0;
         e3_d_in.steer_angle = '0;
         e3_d_in.turn_right  = 1'b1;
         e3_d_in.at_goal     = 1'b1;
      end else begin
         e3_d_in.distance    = e2_dist_ff;
         e3_d_in.steer_angle = turn_wrap[TURN_W-1:0];
         e3_d_in.turn_right  = turn_wrap <= 0;
         e3_d_in.at_goal     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e3_d_ff <= e3_d_in;
      end
   end

   // two-entry output queue
   assign push = advance && e3_v_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      spare_in = spare_ff;
      case (count_ff)
         CNT_W'(0): begin
            if (push) begin
               head_in  = e3_d_ff;
               count_in = CNT_W'(1);
            end
         end
         CNT_W'(1): begin
            if (push && pop) begin
               head_in = e3_d_ff;
            end else if (push) begin
               spare_in = e3_d_ff;
               count_in = CNT_W'(2);
            end else if (pop) begin
               count_in = CNT_W'(0);
            end
         end
         CNT_W'(2): begin
            if (pop) begin
               head_in  = spare_ff;
               count_in = CNT_W'(1);
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = head_ff;

endmodule

@@ hw/rtl/ghd_checker.sv @@
// port checks for the goal heading block and their bind to the top level
module ghd_checker
   import ghd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input ghd_rsp_type rsp_data
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // with the output queue empty the input is never blocked
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output queue");

   // at the goal distance and turn are zero and the turn counts as right
   a_at_goal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.at_goal |->
         rsp_data.distance == '0 && rsp_data.steer_angle == '0 && rsp_data.turn_right)
      else $error("at goal result not zeroed");

   // turn direction flag agrees with the turn sign
   a_turn_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.at_goal |->
         rsp_data.turn_right == ($signed(rsp_data.steer_angle) <= $signed(TURN_W'(0))))
      else $error("turn direction flag disagrees with turn");

   // turn is the shortest one
   a_turn_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_data.steer_angle) <= $signed(TURN_W'(HALF_TURN)) &&
         $signed(rsp_data.steer_angle) >= -$signed(TURN_W'(HALF_TURN)))
      else $error("turn outside half turn range");

endmodule

bind goal_heading_and_distance_top ghd_checker u_ghd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ bench/testbench.sv @@
// testbench for the goal heading and distance block: predicted replies checked per transfer
`timescale 1ns / 100ps

module testbench;

   // coordinate extremes and stimulus sizes
   localparam int COORD_MIN       = -8388608;
   localparam int COORD_MAX       = 8388607;
   localparam int HEAD_PI         = 25736;
   localparam int RANDOM_QUERIES  = 1330;

   // phase boundaries, counted in transfers; hold, watchdog and settle lengths in cycles
   localparam int NO_IDLE_END     = 350;
   localparam int SEND_IDLE_END   = 700;
   localparam int RECV_IDLE_END   = 1050;
   localparam int HOLD_AT         = 100;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_AT_A      = 250;
   localparam int DRAIN_AT_B      = 800;
   localparam int QUIET_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 40;

   // predictor constants
   localparam int     STAGES      = ghd_pkg::DEF_CORDIC_STAGES;
   localparam longint DEG_180     = 23040;
   localparam longint DEG_360     = 46080;
   localparam longint Z_90        = 5898240;
   localparam longint RAD_TO_DEG  = 15019745;
   localparam longint NORM_FLOOR  = 64'sd1 <<< 52;
   localparam longint DIST_MAX    = (64'sd1 <<< 25) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ghd_pkg::ghd_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ghd_pkg::ghd_rsp_type rsp_data;

   ghd_pkg::ghd_req_type pending_queries[$];
   ghd_pkg::ghd_rsp_type awaited_replies[$];

   // arctangent of 2^-i in degrees times 2^16
   longint atan_step [0:15] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                                29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   int  errors = 0;
   int  queries_offered = 0;
   int  queries_taken = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  req_taken = 1'b0;

   goal_heading_and_distance_top #(
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // expected reply for one query: distance, bearing by vectoring rotation, wrapped turn
   function automatic ghd_pkg::ghd_rsp_type goal_reply(ghd_pkg::ghd_req_type q);
      longint dx, dy, ax, ay, x, y, z, xs, ys, g, h, hm, hd, turn;
      longint unsigned n, r, b;
      ghd_pkg::ghd_rsp_type p;
      dx = longint'($signed(q.goal_x)) - longint'($signed(q.cur_x));
      dy = longint'($signed(q.goal_y)) - longint'($signed(q.cur_y));
      h  = longint'($signed(q.heading));
      p  = '0;
      // goal reached: zero turn counts as right
      if (dx == 0 && dy == 0) begin
         p.turn_right = 1'b1;
         p.at_goal = 1'b1;
         return p;
      end
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // floor square root, two bits per step
      n = longint'(ax * ax + ay * ay);
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (r > DIST_MAX) r = DIST_MAX;
      // first-quadrant angle after normalizing the vector up
      x = ax;
      y = ay;
      while (x < NORM_FLOOR && y < NORM_FLOOR) begin
         x = x <<< 1;
         y = y <<< 1;
      end
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += atan_step[i];
         end else begin
            x -= ys;
            y += xs;
            z -= atan_step[i];
         end
      end
      if (z < 0) z = 0;
      if (z > Z_90) z = Z_90;
      g = (z + 256) >>> 9;
      // fold into the quadrant of the goal
      if (dx < 0) g = DEG_180 - g;
      if (dy < 0) g = -g;
      // heading to 1/128 degree, ties away from zero
      hm = (h < 0) ? -h : h;
      hd = (hm * RAD_TO_DEG + (64'sd1 <<< 23)) >>> 24;
      if (h < 0) hd = -hd;
      turn = g - hd;
      if (turn > DEG_180) turn -= DEG_360;
      else if (turn < -DEG_180) turn += DEG_360;
      p.distance = 25'(r);
      p.steer_angle = 16'(turn);
      p.turn_right = (turn <= 0);
      return p;
   endfunction

   task automatic add_query(input int cx, input int cy, input int hd, input int gx,
                            input int gy);
      ghd_pkg::ghd_req_type q;
      q.cur_x = 24'(cx);
      q.cur_y = 24'(cy);
      q.heading = 16'(hd);
      q.goal_x = 24'(gx);
      q.goal_y = 24'(gy);
      pending_queries.insert(pending_queries.size(), q);
   endtask

   function automatic int corner_value();
      case ($urandom_range(3))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   // monitor: check replies, record accepted queries, watchdog
   always @(posedge clock) begin
      ghd_pkg::ghd_rsp_type want;
      bit moved;
      moved = 1'b0;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (awaited_replies.size() == 0) begin
               $error("reply transfer with no query outstanding");
               errors++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_data.distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp_data.distance);
                  errors++;
               end
               if (rsp_data.steer_angle !== want.steer_angle) begin
                  $error("steer_angle: expected %0d, got %0d", $signed(want.steer_angle),
                         $signed(rsp_data.steer_angle));
                  errors++;
               end
               if (rsp_data.turn_right !== want.turn_right) begin
                  $error("turn_right: expected %0b, got %0b", want.turn_right,
                         rsp_data.turn_right);
                  errors++;
               end
               if (rsp_data.at_goal !== want.at_goal) begin
                  $error("at_goal: expected %0b, got %0b", want.at_goal, rsp_data.at_goal);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            req_taken = 1'b1;
            awaited_replies.insert(awaited_replies.size(), goal_reply(req_data));
            queries_taken++;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // driver: offer the next query once the current one is taken
   always @(negedge clock) begin
      int send_pct;
      send_pct = (queries_offered >= RECV_IDLE_END) ? 30 :
                 (queries_offered >= NO_IDLE_END && queries_offered < SEND_IDLE_END) ? 59 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // pause at the drain points until every reply is back
         if (pending_queries.size() != 0 &&
             !((queries_offered == DRAIN_AT_A || queries_offered == DRAIN_AT_B) &&
               awaited_replies.size() != 0) &&
             !($urandom_range(99) < send_pct)) begin
            req_data <= pending_queries.pop_front();
            req_valid <= 1'b1;
            queries_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall by phase, plus one long hold-off to fill the pipeline
   always @(negedge clock) begin
      int recv_pct;
      recv_pct = (queries_taken >= RECV_IDLE_END) ? 30 :
                 (queries_taken >= SEND_IDLE_END) ? 59 : 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && queries_taken >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_pct);
         end
      end
   end

   // stimulus and end of run
   initial begin
      int cx, cy, gx, gy, hd, pick, delta;

      // directed: goal reached, extremes, axes, half turns, heading outside range
      add_query(0, 0, 0, 0, 0);
      add_query(COORD_MAX, COORD_MIN, HEAD_PI, COORD_MAX, COORD_MIN);
      add_query(COORD_MIN, COORD_MIN, 0, COORD_MAX, COORD_MAX);
      add_query(COORD_MAX, COORD_MAX, -HEAD_PI, COORD_MIN, COORD_MIN);
      add_query(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX);
      add_query(COORD_MIN, COORD_MAX, 12868, COORD_MAX, COORD_MIN);
      add_query(100, -50, 0, -300, -50);
      add_query(0, 0, 0, 1, 0);
      add_query(0, 0, 12868, 0, 1);
      add_query(0, 0, 12868, 0, -5);
      add_query(0, 0, -HEAD_PI, -7, 0);
      add_query(0, 0, HEAD_PI, 1, 1);
      add_query(5, 5, 0, 4, 4);
      add_query(0, 0, -32768, 3, -9);
      add_query(0, 0, 32767, -2, 6);
      add_query(COORD_MAX, 0, 0, COORD_MIN, 0);
      add_query(0, COORD_MIN, 0, 0, COORD_MAX);
      add_query(-1, -1, -1, 0, 0);
      add_query(0, 0, 1, 65536, 65536);
      add_query(COORD_MIN, 0, -12868, COORD_MIN, 1);
      add_query(123456, -654321, 4096, -777777, 999999);

      // random mix: wide, near, coincident, axis aligned and corner points, plus wide points with unrestricted headings
      for (int k = 0; k < RANDOM_QUERIES; k++) begin
         pick = $urandom_range(99);
         cx = int'($urandom_range(0, 24'hFFFFFF)) - (1 << 23);
         cy = int'($urandom_range(0, 24'hFFFFFF)) - (1 << 23);
         gx = int'($urandom_range(0, 24'hFFFFFF)) - (1 << 23);
         gy = int'($urandom_range(0, 24'hFFFFFF)) - (1 << 23);
         hd = int'($urandom_range(0, 2 * HEAD_PI)) - HEAD_PI;
         delta = int'($urandom_range(0, 24'hFFFFFF)) - (1 << 23);
         if (pick < 50) begin
            add_query(cx, cy, hd, gx, gy);
         end else if (pick < 60) begin
            add_query(cx, cy, int'($urandom_range(0, 16'hFFFF)), gx, gy);
         end else if (pick < 80) begin
            add_query(cx, cy, hd, cx + int'($urandom_range(0, 80)) - 40,
                      cy + int'($urandom_range(0, 80)) - 40);
         end else if (pick < 85) begin
            add_query(cx, cy, hd, cx, cy);
         end else if (pick < 95) begin
            if ($urandom_range(1)) add_query(cx, cy, hd, cx + delta, cy);
            else add_query(cx, cy, hd, cx, cy + delta);
         end else begin
            add_query(corner_value(), corner_value(), hd, corner_value(), corner_value());
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_queries.size() != 0 || req_valid) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0 && awaited_replies.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ goal_heading_and_distance_top.f @@
hw/rtl/ghd_pkg.sv
hw/rtl/ghd_iter.sv
hw/rtl/goal_heading_and_distance_top.sv
hw/rtl/ghd_checker.sv
bench/testbench.sv
